[design/qhbns_pkg.sv]
// Shared types, codes and constants of the best-node selector.
`timescale 1ns / 1ps
package qhbns_pkg;

  localparam int unsigned NODES_DEFAULT = 16;

  localparam int unsigned EST_W   = 16;
  localparam int unsigned ID_W    = 32;
  localparam int unsigned ALPHA_W = 17;

  localparam logic [ALPHA_W-1:0] ALPHA_RESET = 17'd32768;
  localparam logic [ALPHA_W-1:0] ALPHA_ONE   = 17'h10000;

  // Configuration register index (paddr[2]).
  localparam logic REG_ALPHA = 1'b0;

  localparam logic [2:0] MODE_ADD      = 3'd0;
  localparam logic [2:0] MODE_LARGEST  = 3'd1;
  localparam logic [2:0] MODE_LATEST   = 3'd2;
  localparam logic [2:0] MODE_WEIGHTED = 3'd3;
  localparam logic [2:0] MODE_CLEAR    = 3'd4;

  localparam logic [1:0] STATUS_OK   = 2'd0;
  localparam logic [1:0] STATUS_FULL = 2'd1;
  localparam logic [1:0] STATUS_NONE = 2'd2;

  typedef struct packed {
    logic [2:0]       mode;
    logic [ID_W-1:0]  node_id;
    logic [EST_W-1:0] estimate;
  } in_item_t;

  typedef struct packed {
    logic [ID_W-1:0]  best_id;
    logic [EST_W-1:0] best_score;
    logic [1:0]       status;
  } out_item_t;

  typedef struct packed {
    logic [ID_W-1:0]  key;
    logic [EST_W-1:0] wavg;
    logic [EST_W-1:0] latest;
    logic [EST_W-1:0] largest;
    logic             several;
  } node_entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_MUL,
    ST_WRITE,
    ST_RESP
  } ctrl_state_e;

  typedef struct packed {
    logic start;
    logic scan;
    logic drop;
    logic mul;
    logic write;
    logic finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic scan_mode;
    logic is_add;
    logic scan_done;
    logic full;
    logic out_free;
  } dp_status_t;

endpackage

[design/qhbns_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
module qhbns_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[design/qhbns_ctrl.sv]
// Request sequencer: scan, blend, write back and result hand-off.
`timescale 1ns / 1ps
module qhbns_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  qhbns_pkg::dp_status_t  status_i,
  output qhbns_pkg::ctrl_cmd_t   cmd_o
);

  qhbns_pkg::ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= qhbns_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      qhbns_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          state_d     = qhbns_pkg::ST_SCAN;
        end
      end
      qhbns_pkg::ST_SCAN: begin
        if (!status_i.scan_mode) begin
          state_d = qhbns_pkg::ST_RESP;
        end else begin
          cmd_o.scan = 1'b1;
          if (status_i.scan_done) begin
            if (status_i.is_add && status_i.full) begin
              cmd_o.drop = 1'b1;
              state_d    = qhbns_pkg::ST_RESP;
            end else if (status_i.is_add) begin
              state_d = qhbns_pkg::ST_MUL;
            end else begin
              state_d = qhbns_pkg::ST_RESP;
            end
          end
        end
      end
      qhbns_pkg::ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = qhbns_pkg::ST_WRITE;
      end
      qhbns_pkg::ST_WRITE: begin
        cmd_o.write = 1'b1;
        state_d     = qhbns_pkg::ST_RESP;
      end
      qhbns_pkg::ST_RESP: begin
        // hold until the output register can take the item
        if (status_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = qhbns_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = qhbns_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

[design/qhbns_dp.sv]
// Datapath: node table, scan compare, weighted blend and output register.
`timescale 1ns / 1ps
module qhbns_dp #(
  parameter int unsigned NODES = qhbns_pkg::NODES_DEFAULT
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  qhbns_pkg::ctrl_cmd_t                cmd_i,
  output qhbns_pkg::dp_status_t               status_o,
  input  qhbns_pkg::in_item_t                 in_item_i,
  input  logic [qhbns_pkg::ALPHA_W-1:0]       alpha_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output qhbns_pkg::out_item_t                out_item_o
);

  localparam int unsigned IDX_W = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int unsigned CNT_W = $clog2(NODES + 1);
  localparam int unsigned ENT_W = $bits(qhbns_pkg::node_entry_t);
  localparam int unsigned EW    = qhbns_pkg::EST_W;

  qhbns_pkg::in_item_t    req_q;
  logic [CNT_W-1:0]       count_q;
  logic [CNT_W-1:0]       rd_idx_q;
  logic                   cmp_vld_q;
  logic [IDX_W-1:0]       cmp_idx_q;
  logic                   found_q;
  logic [EW-1:0]          best_score_q;
  logic [qhbns_pkg::ID_W-1:0] best_id_q;
  logic                   hit_q;
  logic [IDX_W-1:0]       hit_idx_q;
  qhbns_pkg::node_entry_t hit_entry_q;
  logic                   drop_q;
  logic signed [34:0]     prod_q;
  logic                   out_valid_q;
  qhbns_pkg::out_item_t   out_q;

  logic                   rd_en;
  logic [ENT_W-1:0]       rd_data;
  qhbns_pkg::node_entry_t entry;
  logic                   we;
  logic [IDX_W-1:0]       waddr;
  qhbns_pkg::node_entry_t wentry;
  logic [EW-1:0]          score;
  logic                   take;
  logic                   key_match;
  logic [EW-1:0]          w_old;
  logic [qhbns_pkg::ALPHA_W-1:0] alpha_sat;
  logic signed [17:0]     alpha_s;
  logic signed [16:0]     diff_s;
  logic signed [34:0]     prod_d;
  logic signed [34:0]     sum;
  logic                   mode_query;
  qhbns_pkg::out_item_t   result;

  assign rd_en = cmd_i.scan && (rd_idx_q < count_q);
  assign entry = qhbns_pkg::node_entry_t'(rd_data);

  qhbns_ram #(
    .WIDTH (ENT_W),
    .DEPTH (NODES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (ENT_W'(wentry)),
    .re_i    (rd_en),
    .raddr_i (rd_idx_q[IDX_W-1:0]),
    .rdata_o (rd_data)
  );

  assign mode_query = (req_q.mode == qhbns_pkg::MODE_LARGEST) ||
                      (req_q.mode == qhbns_pkg::MODE_LATEST)  ||
                      (req_q.mode == qhbns_pkg::MODE_WEIGHTED);

  // Score of the entry under compare for the current query.
  always_comb begin
    case (req_q.mode)
      qhbns_pkg::MODE_LARGEST: score = entry.largest;
      qhbns_pkg::MODE_LATEST:  score = entry.latest;
      default:                 score = entry.several ? entry.wavg : entry.latest;
    endcase
    // weighted keeps the earlier node on a tie and needs a score above zero
    if (req_q.mode == qhbns_pkg::MODE_WEIGHTED) begin
      take = score > best_score_q;
    end else begin
      take = score >= best_score_q;
    end
  end

  assign key_match = entry.key == req_q.node_id;

  // Blend as w + a*(x - w), scaled by 65536.
  assign alpha_sat = alpha_i[qhbns_pkg::ALPHA_W-1] ? qhbns_pkg::ALPHA_ONE : alpha_i;
  assign w_old     = hit_q ? hit_entry_q.wavg : '0;
  assign alpha_s   = $signed({1'b0, alpha_sat});
  assign diff_s    = $signed({1'b0, req_q.estimate}) - $signed({1'b0, w_old});
  assign prod_d    = alpha_s * diff_s;
  assign sum       = $signed({3'b000, w_old, 16'h0000}) + prod_q;

  always_comb begin
    we             = cmd_i.write;
    waddr          = hit_q ? hit_idx_q : count_q[IDX_W-1:0];
    wentry.key     = req_q.node_id;
    wentry.wavg    = sum[31:16];
    wentry.latest  = req_q.estimate;
    wentry.several = hit_q;
    if (hit_q && (hit_entry_q.largest > req_q.estimate)) begin
      wentry.largest = hit_entry_q.largest;
    end else begin
      wentry.largest = req_q.estimate;
    end
  end

  always_comb begin
    result = '0;
    if (req_q.mode == qhbns_pkg::MODE_ADD) begin
      result.status = drop_q ? qhbns_pkg::STATUS_FULL : qhbns_pkg::STATUS_OK;
    end else if (mode_query) begin
      if (found_q) begin
        result.best_id    = best_id_q;
        result.best_score = best_score_q;
      end else begin
        result.status = qhbns_pkg::STATUS_NONE;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      rd_idx_q    <= '0;
      cmp_vld_q   <= 1'b0;
      found_q     <= 1'b0;
      hit_q       <= 1'b0;
      drop_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      cmp_vld_q <= rd_en;
      if (cmd_i.start) begin
        rd_idx_q <= '0;
        found_q  <= 1'b0;
        hit_q    <= 1'b0;
        drop_q   <= 1'b0;
      end
      if (rd_en) begin
        rd_idx_q <= rd_idx_q + CNT_W'(1);
      end
      if (cmp_vld_q) begin
        if ((req_q.mode == qhbns_pkg::MODE_ADD) && key_match) begin
          hit_q <= 1'b1;
        end
        if (mode_query && take) begin
          found_q <= 1'b1;
        end
      end
      if (cmd_i.drop) begin
        drop_q <= 1'b1;
      end
      if (cmd_i.write && !hit_q) begin
        count_q <= count_q + CNT_W'(1);
      end
      if (cmd_i.finish && (req_q.mode == qhbns_pkg::MODE_CLEAR)) begin
        count_q <= '0;
      end
      if (cmd_i.finish) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      req_q        <= in_item_i;
      best_score_q <= '0;
    end
    if (rd_en) begin
      cmp_idx_q <= rd_idx_q[IDX_W-1:0];
    end
    if (cmp_vld_q) begin
      if ((req_q.mode == qhbns_pkg::MODE_ADD) && key_match) begin
        hit_idx_q   <= cmp_idx_q;
        hit_entry_q <= entry;
      end
      if (mode_query && take) begin
        best_score_q <= score;
        best_id_q    <= entry.key;
      end
    end
    if (cmd_i.mul) begin
      prod_q <= prod_d;
    end
    if (cmd_i.finish) begin
      out_q <= result;
    end
  end

  always_comb begin
    status_o.scan_mode = (req_q.mode == qhbns_pkg::MODE_ADD) || mode_query;
    status_o.is_add    = req_q.mode == qhbns_pkg::MODE_ADD;
    status_o.scan_done = (rd_idx_q >= count_q) && !cmp_vld_q;
    status_o.full      = !hit_q && (count_q == CNT_W'(NODES));
    status_o.out_free  = !out_valid_q || !out_stall_i;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

[design/qos_history_best_node_select.sv]
// Top level of the best-node selector: configuration port, sequencer and datapath.
`timescale 1ns / 1ps
// Keeps up to NODES nodes, each with a weighted average, latest and largest
// estimate, and answers one request at a time: add an estimate, return the
// best node by largest, latest or weighted score, or clear the table. Every
// add or query reads the node table once through its single RAM read port,
// one entry per cycle. The next item is taken as soon as the result sits in
// the output register. weight_alpha lies at byte address 0 of the APB port;
// the user must write it only while the block is idle, and the block itself
// does not enforce this.
module qos_history_best_node_select #(
  parameter int unsigned NODES = qhbns_pkg::NODES_DEFAULT
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  qhbns_pkg::in_item_t  in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output qhbns_pkg::out_item_t out_item_o,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  logic [qhbns_pkg::ALPHA_W-1:0] alpha_q;
  qhbns_pkg::ctrl_cmd_t          cmd;
  qhbns_pkg::dp_status_t         status;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q <= qhbns_pkg::ALPHA_RESET;
    end else if (psel && penable && pwrite && pready && (paddr[2] == qhbns_pkg::REG_ALPHA)) begin
      alpha_q <= pwdata[qhbns_pkg::ALPHA_W-1:0];
    end
  end

  assign prdata = (paddr[2] == qhbns_pkg::REG_ALPHA) ?
                  {{(32 - qhbns_pkg::ALPHA_W){1'b0}}, alpha_q} : '0;

  qhbns_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  qhbns_dp #(
    .NODES (NODES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .in_item_i   (in_item_i),
    .alpha_i     (alpha_q),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

[design/qhbns_chk.sv]
// Port-level checks of the best-node selector, bound to the top level.
`timescale 1ns / 1ps
module qhbns_chk (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_stall_o,
  input logic                 out_valid_o,
  input logic                 out_stall_i,
  input qhbns_pkg::out_item_t out_item_o
);

  // A stalled result item stays and holds its value.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("result item dropped or changed under stall");

  // One item at a time: an accepted item blocks the input next cycle.
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken again right after an accept");

  // No qualifying node reports neither id nor score.
  a_none_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_item_o.status == qhbns_pkg::STATUS_NONE) |->
    (out_item_o.best_id == '0) && (out_item_o.best_score == '0))
    else $error("no-node result carries a node");

  // A dropped add reports neither id nor score.
  a_full_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_item_o.status == qhbns_pkg::STATUS_FULL) |->
    (out_item_o.best_id == '0) && (out_item_o.best_score == '0))
    else $error("table-full result carries a node");

endmodule

bind qos_history_best_node_select qhbns_chk u_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_item_o  (out_item_o)
);
